@@ sv/dll_pkg.sv @@
// Shared types and constants of the linked-list cursor block.
package dll_pkg;

  localparam int unsigned NODES_DEF = 64;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned REQ_W     = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR      = 5'd0,
    REQ_INS_HEAD   = 5'd1,
    REQ_INS_TAIL   = 5'd2,
    REQ_CUR_HEAD   = 5'd3,
    REQ_CUR_TAIL   = 5'd4,
    REQ_RD_HEAD    = 5'd5,
    REQ_RD_TAIL    = 5'd6,
    REQ_DEL_HEAD   = 5'd7,
    REQ_DEL_TAIL   = 5'd8,
    REQ_DEL_AFTER  = 5'd9,
    REQ_DEL_BEFORE = 5'd10,
    REQ_INS_AFTER  = 5'd11,
    REQ_INS_BEFORE = 5'd12,
    REQ_RD_CUR     = 5'd13,
    REQ_WRITE_CUR  = 5'd14,
    REQ_NEXT       = 5'd15,
    REQ_PREV       = 5'd16,
    REQ_QUERY      = 5'd17
  } req_e;

  typedef struct packed {
    logic latch;
    logic rd1;
    logic rd2;
    logic wr1;
    logic wr2;
  } dll_cmd_t;

  typedef struct packed {
    logic out_free;
  } dll_stat_t;

endpackage

@@ sv/dll_ctrl.sv @@
// Request sequencer: accept, two read phases, two write phases.
module dll_ctrl
  import dll_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  dll_stat_t stat_i,
  output dll_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RD1  = 5'b00010,
    ST_RD2  = 5'b00100,
    ST_WR1  = 5'b01000,
    ST_WR2  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d = ST_RD1;
        end
      end
      ST_RD1: begin
        cmd_o.rd1 = 1'b1;
        state_d = ST_RD2;
      end
      ST_RD2: begin
        cmd_o.rd2 = 1'b1;
        state_d = ST_WR1;
      end
      ST_WR1: begin
        cmd_o.wr1 = 1'b1;
        state_d = ST_WR2;
      end
      ST_WR2: begin
        if (stat_i.out_free) begin
          cmd_o.wr2 = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/dll_dp.sv @@
// Node pool memories, list pointers, allocator and result register.
module dll_dp
  import dll_pkg::*;
#(
  parameter int unsigned NODES = NODES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dll_cmd_t         cmd_i,
  output dll_stat_t        stat_o,
  input  logic [REQ_W-1:0] req_i,
  input  logic [VAL_W-1:0] value_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [VAL_W-1:0] read_value_o,
  output logic             read_valid_o,
  output logic             error_o,
  output logic             cursor_active_o
);

  localparam int unsigned IW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned CW = $clog2(NODES + 1);
  localparam logic [CW-1:0] NODES_C = CW'(NODES);

  logic [VAL_W-1:0] val_mem   [NODES];
  logic [IW-1:0]    next_mem  [NODES];
  logic [IW-1:0]    prev_mem  [NODES];
  logic [IW-1:0]    stk_mem   [NODES];

  logic [REQ_W-1:0] req_q;
  logic [VAL_W-1:0] wval_q;
  logic [IW-1:0]    head_q, head_d, tail_q, tail_d, cur_q, cur_d;
  logic             nonempty_q, nonempty_d, cvalid_q, cvalid_d;
  logic [CW-1:0]    rcount_q, rcount_d, fresh_q, fresh_d;

  logic [VAL_W-1:0] val_rd_q;
  logic [IW-1:0]    next_rd_q, prev_rd_q, stk_rd_q, n1_q, p1_q;

  logic [IW-1:0]    next_ra, prev_ra, val_ra;
  logic             next_re, prev_re;
  logic             val_we, next_we, prev_we, stk_we;
  logic [IW-1:0]    val_wa, next_wa, prev_wa;
  logic [VAL_W-1:0] val_wd;
  logic [IW-1:0]    next_wd, prev_wd, del_v;

  logic             out_valid_q;
  logic [VAL_W-1:0] rdv_q, rdv_d;
  logic             rv_q, rv_d, err_q, err_d;

  logic             have_rec, alloc_ok, ins_go, take, del_go, push_ok;
  logic [IW-1:0]    slot;

  assign have_rec = (rcount_q != '0);
  assign alloc_ok = have_rec || (fresh_q < NODES_C);
  assign slot     = have_rec ? stk_rd_q : fresh_q[IW-1:0];
  assign push_ok  = (rcount_q < NODES_C);

  always_comb begin
    ins_go = 1'b0;
    del_go = 1'b0;
    del_v  = n1_q;
    case (req_q)
      REQ_INS_HEAD, REQ_INS_TAIL:     ins_go = 1'b1;
      REQ_INS_AFTER, REQ_INS_BEFORE:  ins_go = cvalid_q;
      REQ_DEL_HEAD: begin
        del_go = nonempty_q;
        del_v  = head_q;
      end
      REQ_DEL_TAIL: begin
        del_go = nonempty_q;
        del_v  = tail_q;
      end
      REQ_DEL_AFTER: begin
        del_go = cvalid_q && (cur_q != tail_q);
        del_v  = n1_q;
      end
      REQ_DEL_BEFORE: begin
        del_go = cvalid_q && (cur_q != head_q);
        del_v  = p1_q;
      end
      default: ;
    endcase
  end

  assign take = ins_go && alloc_ok;

  // read address selection
  always_comb begin
    next_re = cmd_i.rd1 || cmd_i.rd2;
    prev_re = cmd_i.rd1 || cmd_i.rd2;
    next_ra = (req_q == REQ_DEL_HEAD) ? head_q : cur_q;
    prev_ra = (req_q == REQ_DEL_TAIL) ? tail_q : cur_q;
    if (cmd_i.rd2) begin
      next_ra = next_rd_q;
      prev_ra = prev_rd_q;
    end
    case (req_q)
      REQ_RD_HEAD: val_ra = head_q;
      REQ_RD_TAIL: val_ra = tail_q;
      default:     val_ra = cur_q;
    endcase
  end

  // write plan
  always_comb begin
    val_we  = 1'b0;
    next_we = 1'b0;
    prev_we = 1'b0;
    stk_we  = 1'b0;
    val_wa  = slot;
    val_wd  = wval_q;
    next_wa = slot;
    next_wd = head_q;
    prev_wa = slot;
    prev_wd = tail_q;
    if (cmd_i.wr1) begin
      stk_we = del_go && push_ok;
      case (req_q)
        REQ_INS_HEAD: begin
          val_we  = take;
          next_we = take;
          next_wd = head_q;
          prev_we = take && nonempty_q;
          prev_wa = head_q;
          prev_wd = slot;
        end
        REQ_INS_TAIL: begin
          val_we  = take;
          prev_we = take;
          prev_wd = tail_q;
          next_we = take && nonempty_q;
          next_wa = tail_q;
          next_wd = slot;
        end
        REQ_DEL_AFTER: begin
          next_we = del_go && (n1_q != tail_q);
          next_wa = cur_q;
          next_wd = next_rd_q;
          prev_we = next_we;
          prev_wa = next_rd_q;
          prev_wd = cur_q;
        end
        REQ_DEL_BEFORE: begin
          prev_we = del_go && (p1_q != head_q);
          prev_wa = cur_q;
          prev_wd = prev_rd_q;
          next_we = prev_we;
          next_wa = prev_rd_q;
          next_wd = cur_q;
        end
        REQ_INS_AFTER: begin
          val_we  = take;
          prev_we = take;
          prev_wd = cur_q;
          next_we = take;
          next_wd = n1_q;
        end
        REQ_INS_BEFORE: begin
          val_we  = take;
          next_we = take;
          next_wd = cur_q;
          prev_we = take;
          prev_wd = p1_q;
        end
        REQ_WRITE_CUR: begin
          val_we = cvalid_q;
          val_wa = cur_q;
        end
        default: ;
      endcase
    end
    if (cmd_i.wr2) begin
      case (req_q)
        REQ_INS_AFTER: begin
          next_we = take;
          next_wa = cur_q;
          next_wd = slot;
          prev_we = take && (cur_q != tail_q);
          prev_wa = n1_q;
          prev_wd = slot;
        end
        REQ_INS_BEFORE: begin
          prev_we = take;
          prev_wa = cur_q;
          prev_wd = slot;
          next_we = take && (cur_q != head_q);
          next_wa = p1_q;
          next_wd = slot;
        end
        default: ;
      endcase
    end
  end

  // next list state and result
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    cur_d      = cur_q;
    nonempty_d = nonempty_q;
    cvalid_d   = cvalid_q;
    rcount_d   = rcount_q;
    fresh_d    = fresh_q;
    rdv_d      = '0;
    rv_d       = 1'b0;
    err_d      = ins_go && !alloc_ok;
    if (take) begin
      if (have_rec) rcount_d = rcount_q - CW'(1);
      else fresh_d = fresh_q + CW'(1);
    end
    if (del_go && push_ok) rcount_d = rcount_q + CW'(1);
    case (req_q)
      REQ_CLEAR: begin
        rcount_d   = '0;
        fresh_d    = '0;
        nonempty_d = 1'b0;
        cvalid_d   = 1'b0;
      end
      REQ_INS_HEAD: begin
        if (take) begin
          if (!nonempty_q) tail_d = slot;
          head_d = slot;
          nonempty_d = 1'b1;
        end
      end
      REQ_INS_TAIL: begin
        if (take) begin
          if (!nonempty_q) head_d = slot;
          tail_d = slot;
          nonempty_d = 1'b1;
        end
      end
      REQ_CUR_HEAD: begin
        cur_d = head_q;
        cvalid_d = nonempty_q;
      end
      REQ_CUR_TAIL: begin
        cur_d = tail_q;
        cvalid_d = nonempty_q;
      end
      REQ_RD_HEAD, REQ_RD_TAIL: begin
        err_d = !nonempty_q;
        rv_d  = nonempty_q;
        rdv_d = nonempty_q ? val_rd_q : '0;
      end
      REQ_RD_CUR: begin
        err_d = !cvalid_q;
        rv_d  = cvalid_q;
        rdv_d = cvalid_q ? val_rd_q : '0;
      end
      REQ_DEL_HEAD, REQ_DEL_TAIL: begin
        if (del_go) begin
          if (head_q == tail_q) begin
            nonempty_d = 1'b0;
            cvalid_d   = 1'b0;
          end else begin
            if (cvalid_q && (cur_q == del_v)) cvalid_d = 1'b0;
            if (req_q == REQ_DEL_HEAD) head_d = n1_q;
            else tail_d = p1_q;
          end
        end
      end
      REQ_DEL_AFTER: begin
        if (del_go && (n1_q == tail_q)) tail_d = cur_q;
      end
      REQ_DEL_BEFORE: begin
        if (del_go && (p1_q == head_q)) head_d = cur_q;
      end
      REQ_INS_AFTER: begin
        if (take && (cur_q == tail_q)) tail_d = slot;
      end
      REQ_INS_BEFORE: begin
        if (take && (cur_q == head_q)) head_d = slot;
      end
      REQ_NEXT: begin
        if (cvalid_q) begin
          if (cur_q == tail_q) cvalid_d = 1'b0;
          else cur_d = n1_q;
        end
      end
      REQ_PREV: begin
        if (cvalid_q) begin
          if (cur_q == head_q) cvalid_d = 1'b0;
          else cur_d = p1_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (val_we) val_mem[val_wa] <= val_wd;
    if (cmd_i.rd1) val_rd_q <= val_mem[val_ra];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (next_re) next_rd_q <= next_mem[next_ra];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (prev_re) prev_rd_q <= prev_mem[prev_ra];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[rcount_q[IW-1:0]] <= del_v;
    if (cmd_i.rd1) stk_rd_q <= stk_mem[IW'(rcount_q - CW'(1))];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q  <= req_i;
      wval_q <= value_i;
    end
    if (cmd_i.rd2) begin
      n1_q <= next_rd_q;
      p1_q <= prev_rd_q;
    end
    if (cmd_i.wr2) begin
      rdv_q <= rdv_d;
      rv_q  <= rv_d;
      err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      cur_q       <= '0;
      nonempty_q  <= 1'b0;
      cvalid_q    <= 1'b0;
      rcount_q    <= '0;
      fresh_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wr2) begin
        head_q     <= head_d;
        tail_q     <= tail_d;
        cur_q      <= cur_d;
        nonempty_q <= nonempty_d;
        cvalid_q   <= cvalid_d;
        rcount_q   <= rcount_d;
        fresh_q    <= fresh_d;
      end
      if (cmd_i.wr2) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign read_value_o    = rdv_q;
  assign read_valid_o    = rv_q;
  assign error_o         = err_q;
  assign cursor_active_o = cvalid_q;

endmodule

@@ sv/doubly_linked_list_cursor_top.sv @@
// Top level of the linked-list cursor block.
// A doubly linked list of signed 32-bit values in a pool of NODES nodes, with
// head, tail and a cursor; every request gives one result. A request passes
// through five steps (accept, two pool reads, two writes): the second read
// fetches the neighbor of a neighbor, and the next and prev pool memories,
// each with a single write port, take their up to two writes per request in
// separate steps. The result is registered in the second write step, and a
// new request is taken only once the previous one is through its write steps;
// the next request is taken while a result waits downstream, and a request
// holds in its last write step until that result is accepted. Pool memories
// are not cleared at reset and need no clearing pass: the list starts empty.
module doubly_linked_list_cursor_top
  import dll_pkg::*;
#(
  parameter int unsigned NODES = NODES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic [4:0]  s_axis_tuser_i,   // [4:0] req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] read_value, [32] cursor_active
  output logic [1:0]  m_axis_tuser_o    // [0] read_valid, [1] error
);

  dll_cmd_t         cmd;
  dll_stat_t        stat;
  logic [VAL_W-1:0] read_value;
  logic             read_valid, error, cursor_active;

  dll_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dll_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .req_i           (s_axis_tuser_i),
    .value_i         (s_axis_tdata_i),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .read_value_o    (read_value),
    .read_valid_o    (read_valid),
    .error_o         (error),
    .cursor_active_o (cursor_active)
  );

  assign m_axis_tdata_o = {7'd0, cursor_active, read_value};
  assign m_axis_tuser_o = {error, read_valid};

endmodule

@@ sim/testbench.sv @@
// Testbench for the linked-list cursor block: random and directed requests against a predictor.
`timescale 1ns / 100ps

module testbench;
  import dll_pkg::*;

  localparam int unsigned POOL = 64;
  localparam int unsigned WATCHDOG = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic [4:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  typedef struct packed {
    logic [31:0] rd_val;
    logic        rd_ok;
    logic        err;
    logic        cur_on;
  } resp_t;

  resp_t       pending_resp[$];
  int unsigned fail_cnt = 0;
  int unsigned idle_cycles = 0;
  bit          hold_off = 1'b0;
  bit          stall_rand = 1'b1;

  // predictor state
  logic [31:0] pv[POOL];
  logic [5:0]  pn[POOL];
  logic [5:0]  pp[POOL];
  logic [5:0]  stk[POOL];
  int unsigned stk_cnt, fresh_cnt;
  logic [5:0]  hd, tl, cur;
  bit          nonempty, cur_ok;
  int unsigned list_len;

  always #5 clk_i = ~clk_i;

  doubly_linked_list_cursor_top i_dut (.*);

  function automatic bit alloc_node(output logic [5:0] slot);
    slot = '0;
    if (stk_cnt > 0) begin
      stk_cnt--;
      slot = stk[stk_cnt];
      return 1'b1;
    end
    if (fresh_cnt < POOL) begin
      slot = fresh_cnt[5:0];
      fresh_cnt++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void free_node(logic [5:0] slot);
    if (stk_cnt < POOL) begin
      stk[stk_cnt] = slot;
      stk_cnt++;
    end
    list_len--;
  endfunction

  function automatic resp_t predict_list(logic [4:0] code, logic [31:0] val);
    resp_t r;
    logic [5:0] n, v;
    logic [5:0] c;
    r = '0;
    c = cur;
    case (code)
      REQ_CLEAR: begin
        stk_cnt = 0; fresh_cnt = 0; nonempty = 0; cur_ok = 0; list_len = 0;
      end
      REQ_INS_HEAD: begin
        if (!alloc_node(n)) r.err = 1;
        else begin
          pv[n] = val; pn[n] = hd;
          if (nonempty) pp[hd] = n; else tl = n;
          hd = n; nonempty = 1; list_len++;
        end
      end
      REQ_INS_TAIL: begin
        if (!alloc_node(n)) r.err = 1;
        else begin
          pv[n] = val; pp[n] = tl;
          if (nonempty) pn[tl] = n; else hd = n;
          tl = n; nonempty = 1; list_len++;
        end
      end
      REQ_CUR_HEAD: begin cur = hd; cur_ok = nonempty; end
      REQ_CUR_TAIL: begin cur = tl; cur_ok = nonempty; end
      REQ_RD_HEAD, REQ_RD_TAIL: begin
        if (!nonempty) r.err = 1;
        else begin
          r.rd_val = pv[code == REQ_RD_HEAD ? hd : tl]; r.rd_ok = 1;
        end
      end
      REQ_DEL_HEAD, REQ_DEL_TAIL: begin
        if (nonempty) begin
          v = (code == REQ_DEL_HEAD) ? hd : tl;
          if (hd == tl) begin
            nonempty = 0; cur_ok = 0;
          end else begin
            if (cur_ok && cur == v) cur_ok = 0;
            if (code == REQ_DEL_HEAD) hd = pn[v]; else tl = pp[v];
          end
          free_node(v);
        end
      end
      REQ_DEL_AFTER: begin
        if (cur_ok && c != tl) begin
          v = pn[c];
          if (v != tl) begin pn[c] = pn[v]; pp[pn[v]] = c; end
          else tl = c;
          free_node(v);
        end
      end
      REQ_DEL_BEFORE: begin
        if (cur_ok && c != hd) begin
          v = pp[c];
          if (v != hd) begin pp[c] = pp[v]; pn[pp[v]] = c; end
          else hd = c;
          free_node(v);
        end
      end
      REQ_INS_AFTER: begin
        if (cur_ok) begin
          if (!alloc_node(n)) r.err = 1;
          else begin
            pv[n] = val; pp[n] = c; pn[n] = pn[c];
            if (c == tl) tl = n; else pp[pn[c]] = n;
            pn[c] = n; list_len++;
          end
        end
      end
      REQ_INS_BEFORE: begin
        if (cur_ok) begin
          if (!alloc_node(n)) r.err = 1;
          else begin
            pv[n] = val; pn[n] = c; pp[n] = pp[c];
            if (c == hd) hd = n; else pn[pp[c]] = n;
            pp[c] = n; list_len++;
          end
        end
      end
      REQ_RD_CUR: begin
        if (!cur_ok) r.err = 1;
        else begin r.rd_val = pv[c]; r.rd_ok = 1; end
      end
      REQ_WRITE_CUR: if (cur_ok) pv[c] = val;
      REQ_NEXT: if (cur_ok) begin
        if (c == tl) cur_ok = 0; else cur = pn[c];
      end
      REQ_PREV: if (cur_ok) begin
        if (c == hd) cur_ok = 0; else cur = pp[c];
      end
      default: ;
    endcase
    r.cur_on = cur_ok;
    return r;
  endfunction

  task automatic send_req(logic [4:0] code, logic [31:0] val);
    int unsigned gap;
    if ($urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= code;
    s_axis_tdata_i <= val;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_resp.push_back(predict_list(code, val));
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0;
      default: return $urandom();
    endcase
  endfunction

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_resp.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_req(REQ_RD_HEAD, 0);
    send_req(REQ_RD_CUR, 0);
    send_req(REQ_DEL_HEAD, 0);
    send_req(REQ_CUR_HEAD, 0);
    send_req(REQ_PREV, 0);
    send_req(REQ_INS_AFTER, 5);
    send_req(REQ_INS_HEAD, 32'h8000_0000);
    send_req(REQ_INS_TAIL, 32'h7fff_ffff);
    send_req(REQ_CUR_TAIL, 0);
    send_req(REQ_INS_BEFORE, 32'hffff_ffff);
    send_req(REQ_INS_AFTER, 32'h1234_5678);
    send_req(REQ_RD_CUR, 0);
    send_req(REQ_WRITE_CUR, 32'hdead_beef);
    send_req(REQ_RD_TAIL, 0);
    send_req(REQ_DEL_BEFORE, 0);
    send_req(REQ_DEL_AFTER, 0);
    send_req(REQ_NEXT, 0);
    send_req(REQ_QUERY, 0);
    send_req(REQ_CUR_HEAD, 0);
    send_req(REQ_DEL_HEAD, 0);
    send_req(REQ_QUERY, 0);
    send_req(5'd31, 32'hffff_ffff);
    send_req(REQ_DEL_TAIL, 0);
    send_req(REQ_CLEAR, 0);
    send_req(REQ_RD_TAIL, 0);
  endtask

  task automatic test_full_pool();
    send_req(REQ_CLEAR, 0);
    repeat (POOL + 2) send_req($urandom_range(0, 1) ? REQ_INS_HEAD : REQ_INS_TAIL, rand_val());
    send_req(REQ_CUR_HEAD, 0);
    send_req(REQ_INS_AFTER, rand_val());
    send_req(REQ_INS_BEFORE, rand_val());
    send_req(REQ_DEL_AFTER, 0);
    send_req(REQ_INS_AFTER, rand_val());
    drain_results();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    repeat (12) send_req(5'($urandom_range(1, 17)), rand_val());
    drain_results();
  endtask

  task automatic test_random(int unsigned count);
    logic [4:0] code;
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(0, 19))
        0: code = (list_len > 40) ? REQ_CLEAR : REQ_QUERY;
        1: code = 5'($urandom_range(18, 31));
        2, 3: code = (list_len < 50) ? REQ_INS_TAIL : REQ_DEL_HEAD;
        4: code = (list_len < 50) ? REQ_INS_HEAD : REQ_DEL_TAIL;
        5: code = cur_ok ? REQ_NEXT : REQ_CUR_HEAD;
        6: code = cur_ok ? REQ_PREV : REQ_CUR_TAIL;
        default: code = 5'($urandom_range(1, 17));
      endcase
      send_req(code, rand_val());
    end
  endtask

  // receiver: random stalls, or a long hold-off
  initial begin
    int unsigned gap;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        m_axis_tready_i <= 1'b0;
        for (int unsigned k = 0; k < 60; k++) @(posedge clk_i);
        hold_off = 1'b0;
      end else if (stall_rand && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        repeat (gap - 1) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    resp_t got, exp;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tdata_o[31:0], m_axis_tuser_o[0], m_axis_tuser_o[1], m_axis_tdata_o[32]};
      if (pending_resp.size() == 0) begin
        $error("unexpected result %h", got);
        fail_cnt++;
      end else begin
        exp = pending_resp.pop_front();
        if (got.rd_val !== exp.rd_val) begin
          $error("read_value exp %h got %h", exp.rd_val, got.rd_val); fail_cnt++;
        end
        if (got.rd_ok !== exp.rd_ok) begin
          $error("read_valid exp %b got %b", exp.rd_ok, got.rd_ok); fail_cnt++;
        end
        if (got.err !== exp.err) begin
          $error("error exp %b got %b", exp.err, got.err); fail_cnt++;
        end
        if (got.cur_on !== exp.cur_on) begin
          $error("cursor_active exp %b got %b", exp.cur_on, got.cur_on); fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    stk_cnt = 0; fresh_cnt = 0; hd = 0; tl = 0; cur = 0;
    nonempty = 0; cur_ok = 0; list_len = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    drain_results();
    test_full_pool();
    test_backpressure();
    test_random(400);
    drain_results();
    test_random(330);
    drain_results();
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0 && pending_resp.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/dll_pkg.sv
sv/dll_ctrl.sv
sv/dll_dp.sv
sv/doubly_linked_list_cursor_top.sv
sim/testbench.sv
